// ===== rtl/core/epfm_pkg.sv =====
`timescale 1ns / 1ps

package epfm_pkg;

  // Widths of the payload and the tick counter, and the job queue depth
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned JOB_DEPTH_DEF   = 2;

  // Reset value of reference_hz and the ceiling of the reported period
  localparam logic [DATA_W-1:0] REF_HZ_RESET = 32'd48000000;
  localparam logic [DATA_W-1:0] PERIOD_LIMIT = 32'hFFFFFFFF;

  // Configuration port: byte addresses 0 and 4, register index in paddr[2]
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam logic        REG_REFERENCE_HZ = 1'b0;

  // Radix-2 divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // One finished measurement waiting for its quotient
  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] period;
    logic              overflowed;
  } job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

// ===== rtl/core/epfm_front.sv =====
`timescale 1ns / 1ps

// Tick counter: arms on one rising edge, counts ticks, emits a job on the next
module epfm_front import epfm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              rising_edge,
  input  logic [DATA_W-1:0] reference_hz,
  output logic              job_push,
  output job_t              job
);

  logic                   armed_r,    armed_nxt;
  logic [COUNT_WIDTH-1:0] count_r,    count_nxt;
  logic                   ovf_r,      ovf_nxt;
  logic                   at_max;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   big;
  logic [DATA_W-1:0]      period;

  // Saturating increment
  assign at_max    = &count_r;
  assign count_inc = at_max ? count_r : count_r + COUNT_WIDTH'(1);

  // Clamp the count to the 32-bit period field
  if (COUNT_WIDTH > DATA_W) begin : g_wide
    assign big    = |count_inc[COUNT_WIDTH-1:DATA_W];
    assign period = big ? PERIOD_LIMIT : count_inc[DATA_W-1:0];
  end else begin : g_narrow
    assign big    = 1'b0;
    assign period = DATA_W'(count_inc);
  end

  // Next state
  always_comb begin
    armed_nxt = armed_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (tick) begin
      if (!armed_r) begin
        if (rising_edge) begin
          armed_nxt = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end else begin
        count_nxt = count_inc;
        ovf_nxt   = ovf_r | at_max;
        if (rising_edge) begin
          armed_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Second edge: hand the measurement to the job queue; a count too wide
  // for the period field gives a zero quotient, so the dividend is zeroed
  assign job_push       = tick && armed_r && rising_edge;
  assign job.dividend   = big ? '0 : reference_hz;
  assign job.period     = period;
  assign job.overflowed = ovf_r | at_max | big;

endmodule

// ===== rtl/core/epfm_job_fifo.sv =====
`timescale 1ns / 1ps

// Short queue of finished measurements between counter and divider
module epfm_job_fifo import epfm_pkg::*; #(
  parameter int unsigned JOB_DEPTH = JOB_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             mem_r [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r,   fill_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_job = mem_r[rd_ptr_r];
  assign full   = (fill_r == CNT_W'(JOB_DEPTH));
  assign empty  = (fill_r == '0);

endmodule

// ===== rtl/core/epfm_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, with a one-item result register
module epfm_divider import epfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_empty,
  input  job_t              job,
  output logic              job_pop,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] out_frequency_hz,
  output logic [DATA_W-1:0] out_period_ticks,
  output logic              out_overflowed
);

  div_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r;
  logic [DATA_W-1:0]    dvd_r;     // dividend shifting out, quotient shifting in
  logic [DATA_W-1:0]    div_r;
  logic [DATA_W-1:0]    rem_r;
  logic                 ovf_r;
  logic                 res_valid_r;
  logic [DATA_W-1:0]    res_freq_r;
  logic [DATA_W-1:0]    res_period_r;
  logic                 res_ovf_r;

  logic                 load, run, res_wr, last_step;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 ge;

  assign last_step = (step_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (!job_empty) state_nxt = DIV_RUN;
      DIV_RUN:  if (last_step) state_nxt = DIV_DONE;
      DIV_DONE: if (!res_valid_r || pop) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  // Controls
  always_comb begin
    load   = 1'b0;
    run    = 1'b0;
    res_wr = 1'b0;
    unique case (state_r)
      DIV_IDLE: load   = !job_empty;
      DIV_RUN:  run    = 1'b1;
      DIV_DONE: res_wr = !res_valid_r || pop;
      default:  load   = 1'b0;
    endcase
  end

  assign job_pop = load;

  // One trial subtraction
  assign shifted = {rem_r, dvd_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = (shifted >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DIV_IDLE;
      step_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        step_r <= '0;
      end else if (run) begin
        step_r <= step_r + DIV_CNT_W'(1);
      end
      if (res_wr) begin
        res_valid_r <= 1'b1;
      end else if (pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= job.dividend;
      div_r <= job.period;
      rem_r <= '0;
      ovf_r <= job.overflowed;
    end else if (run) begin
      rem_r <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      dvd_r <= {dvd_r[DATA_W-2:0], ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_freq_r   <= dvd_r;
      res_period_r <= div_r;
      res_ovf_r    <= ovf_r;
    end
  end

  assign empty            = !res_valid_r;
  assign out_frequency_hz = res_freq_r;
  assign out_period_ticks = res_period_r;
  assign out_overflowed   = res_ovf_r;

endmodule

// ===== rtl/core/edge_period_frequency_meter_unit.sv =====
`timescale 1ns / 1ps

// Reciprocal frequency meter. Each accepted item is one reference tick; a
// rising edge arms the meter, the next rising edge ends the measurement, so
// every other period of the signal is measured. The tick counter takes one
// item per clock while full is low; full rises only while all JOB_DEPTH
// entries of the job queue are occupied. Each result then passes through a
// radix-2 divider: one load step, one step per quotient bit and one
// hand-off step, which waits for a free result register; between results
// input runs at one item per clock until the queue fills. The quotient
// frequency_hz = reference_hz / period_ticks is floored; reference_hz sits
// at byte address 0 of the configuration port and resets to 48 MHz.
module edge_period_frequency_meter_unit import epfm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int unsigned JOB_DEPTH   = JOB_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input queue
  input  logic                  push,
  output logic                  full,
  input  logic                  in_rising_edge,
  // result queue
  output logic                  empty,
  input  logic                  pop,
  output logic [DATA_W-1:0]     out_frequency_hz,
  output logic [DATA_W-1:0]     out_period_ticks,
  output logic                  out_overflowed,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [DATA_W-1:0] ref_hz_r;
  logic              tick;
  logic              job_push, job_pop, job_full, job_empty;
  job_t              wr_job, rd_job;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_hz_r <= REF_HZ_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_REFERENCE_HZ) begin
      ref_hz_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_REFERENCE_HZ) ? ref_hz_r : '0;

  // Input handshake
  assign full = job_full;
  assign tick = push && !full;

  epfm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .rising_edge (in_rising_edge),
    .reference_hz(ref_hz_r),
    .job_push    (job_push),
    .job         (wr_job)
  );

  epfm_job_fifo #(
    .JOB_DEPTH(JOB_DEPTH)
  ) u_jobs (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wr_job(wr_job),
    .pop   (job_pop),
    .rd_job(rd_job),
    .full  (job_full),
    .empty (job_empty)
  );

  epfm_divider u_div (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_empty       (job_empty),
    .job             (rd_job),
    .job_pop         (job_pop),
    .pop             (pop),
    .empty           (empty),
    .out_frequency_hz(out_frequency_hz),
    .out_period_ticks(out_period_ticks),
    .out_overflowed  (out_overflowed)
  );

endmodule

// ===== rtl/core/epfm_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the meter
module epfm_checker import epfm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [DATA_W-1:0]     out_frequency_hz,
  input logic [DATA_W-1:0]     out_period_ticks,
  input logic                  out_overflowed,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0]     pwdata,
  input logic [DATA_W-1:0]     prdata,
  input logic                  pready
);

  // Reset leaves no result and room for input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown straight after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full straight after reset");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_frequency_hz) &&
                          $stable(out_period_ticks) && $stable(out_overflowed)))
    else $error("waiting result changed");

  // Period is never zero, so the quotient is always defined
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_period_ticks != '0))
    else $error("zero period reported");

  // A write to reference_hz reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[2] == REG_REFERENCE_HZ)
    |=> (paddr[2] != REG_REFERENCE_HZ || prdata == $past(pwdata)))
    else $error("reference_hz read-back wrong");

endmodule

bind edge_period_frequency_meter_unit epfm_checker u_epfm_checker (.*);
